// File: rtl/slot_stats_smoother_unit_defines.svh
// Assertion macros for the slot statistics smoother.
`ifndef SLOT_STATS_SMOOTHER_UNIT_DEFINES_SVH
`define SLOT_STATS_SMOOTHER_UNIT_DEFINES_SVH

`ifndef SYNTH

// Condition that must hold at every clock edge outside reset.
`define SSS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("slot_stats_smoother: invariant violated");

// Consequent that must hold in the cycle after the antecedent.
`define SSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot_stats_smoother: sequence violated");

`else

`define SSS_ASSERT_ALWAYS(lbl, cond)
`define SSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/sss_pkg.sv
// Shared types, constants and functions of the slot statistics smoother.
package sss_pkg;

  localparam int unsigned SLOT_COUNT   = 24;
  localparam int unsigned SMOOTH_SHIFT = 3;
  localparam int unsigned SLOT_IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int unsigned SLOT_W   = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned RAND_W   = 3;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned ACC_W    = BYTE_W + SMOOTH_SHIFT;

  localparam logic [BYTE_W-1:0] ERASED = 8'hff;
  localparam logic [BYTE_W-1:0] VALID_LIMIT_RST = 8'd254;
  localparam logic              SPLIT_RST = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPLIT_EW    = 1'd1;

  // Nonvolatile write classes.
  localparam logic [OP_W-1:0] OP_NONE        = 2'd0;
  localparam logic [OP_W-1:0] OP_ERASE       = 2'd1;
  localparam logic [OP_W-1:0] OP_WRITE       = 2'd2;
  localparam logic [OP_W-1:0] OP_ERASE_WRITE = 2'd3;

  typedef struct packed {
    logic capture;  // take the request into the working registers
    logic exec;     // update the stores and load the result register
  } sss_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] last_value;
    logic [BYTE_W-1:0] smoothed_value;
    logic [OP_W-1:0]   last_op;
    logic [OP_W-1:0]   smoothed_op;
  } sss_result_t;

  function automatic logic [OP_W-1:0] write_class(
    input logic [BYTE_W-1:0] old_v,
    input logic [BYTE_W-1:0] tgt,
    input logic              split
  );
    logic [OP_W-1:0] op;
    if (tgt == old_v) begin
      op = OP_NONE;
    end else if (tgt == ERASED) begin
      op = split ? OP_ERASE : OP_ERASE_WRITE;
    end else if (split && ((tgt & old_v) == tgt)) begin
      op = OP_WRITE;
    end else begin
      op = OP_ERASE_WRITE;
    end
    return op;
  endfunction

endpackage

// File: rtl/sss_in_if.sv
// Request channel carrying slot, sample and random bits.
interface sss_in_if;
  logic                           valid;
  logic                           ready;
  logic [sss_pkg::SLOT_W-1:0]     slot;
  logic [sss_pkg::BYTE_W-1:0]     sample;
  logic [sss_pkg::RAND_W-1:0]     rand_bits;

  modport source (output valid, output slot, output sample, output rand_bits, input ready);
  modport sink   (input valid, input slot, input sample, input rand_bits, output ready);
endinterface

// File: rtl/sss_out_if.sv
// Result channel carrying the updated values and write classes.
interface sss_out_if;
  logic                           valid;
  logic                           ready;
  logic [sss_pkg::BYTE_W-1:0]     last_value;
  logic [sss_pkg::BYTE_W-1:0]     smoothed_value;
  logic [sss_pkg::OP_W-1:0]       last_op;
  logic [sss_pkg::OP_W-1:0]       smoothed_op;

  modport source (output valid, output last_value, output smoothed_value,
                  output last_op, output smoothed_op, input ready);
  modport sink   (input valid, input last_value, input smoothed_value,
                  input last_op, input smoothed_op, output ready);
endinterface

// File: rtl/sss_ctrl.sv
// Controller: sequences capture and update of one request at a time.
module sss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sss_pkg::sss_cmd_t cmd
);
  import sss_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        // The update waits until the result register can take the new result.
        if (out_free) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/sss_datapath.sv
// Datapath: slot stores, smoothing arithmetic, write classes and result register.
module sss_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sss_pkg::sss_cmd_t               cmd,
  input  logic                            cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [sss_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [sss_pkg::SLOT_W-1:0]      in_slot,
  input  logic [sss_pkg::BYTE_W-1:0]      in_sample,
  input  logic [sss_pkg::RAND_W-1:0]      in_rand_bits,
  output sss_pkg::sss_result_t            result
);
  import sss_pkg::*;

  logic [BYTE_W-1:0]       valid_limit_r;
  logic                    split_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [BYTE_W-1:0]       sample_r;
  logic [SMOOTH_SHIFT-1:0] rnd_r;

  logic [BYTE_W-1:0]       sample_mem [SLOT_COUNT];
  logic [BYTE_W-1:0]       smooth_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   written_r;

  logic [SLOT_IDX_W-1:0]   idx;
  logic                    in_range;
  logic [BYTE_W-1:0]       old_last;
  logic [BYTE_W-1:0]       old_smooth;
  logic [ACC_W-1:0]        acc;
  logic [BYTE_W-1:0]       new_smooth;
  sss_result_t             res_nxt;
  sss_result_t             result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_limit_r <= VALID_LIMIT_RST;
      split_r       <= SPLIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_VALID_LIMIT: valid_limit_r <= cfg_data[BYTE_W-1:0];
        CFG_SPLIT_EW:    split_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      slot_r   <= in_slot;
      sample_r <= in_sample;
      rnd_r    <= in_rand_bits[SMOOTH_SHIFT-1:0];
    end
  end

  assign in_range = (int'(slot_r) < SLOT_COUNT);
  assign idx      = slot_r[SLOT_IDX_W-1:0];

  // A slot never written since reset reads as erased.
  assign old_last   = (in_range && written_r[idx]) ? sample_mem[idx] : ERASED;
  assign old_smooth = (in_range && written_r[idx]) ? smooth_mem[idx] : ERASED;

  // (2^s - 1) * old + sample + rnd, built as a shift and subtract.
  assign acc = {old_smooth, {SMOOTH_SHIFT{1'b0}}} - ACC_W'(old_smooth)
             + ACC_W'(sample_r) + ACC_W'(rnd_r);

  always_comb begin
    if (old_smooth > valid_limit_r) begin
      new_smooth = sample_r;
    end else if (old_smooth == sample_r) begin
      new_smooth = old_smooth;
    end else begin
      new_smooth = acc[ACC_W-1:SMOOTH_SHIFT];
    end
  end

  always_comb begin
    if (in_range) begin
      res_nxt.last_value     = sample_r;
      res_nxt.smoothed_value = new_smooth;
      res_nxt.last_op        = write_class(old_last, sample_r, split_r);
      res_nxt.smoothed_op    = write_class(old_smooth, new_smooth, split_r);
    end else begin
      res_nxt.last_value     = ERASED;
      res_nxt.smoothed_value = ERASED;
      res_nxt.last_op        = OP_NONE;
      res_nxt.smoothed_op    = OP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (cmd.exec && in_range) begin
      written_r[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && in_range) begin
      sample_mem[idx] <= sample_r;
      smooth_mem[idx] <= new_smooth;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result_r <= res_nxt;
    end
  end

  assign result = result_r;

endmodule

// File: rtl/slot_stats_smoother_unit.sv
// Top level of the slot statistics smoother.
//
//   Channel  Direction  Contents
//   in_ch    sink       slot, sample, rand_bits
//   out_ch   source     last_value, smoothed_value, last_op, smoothed_op
//   cfg_*    write      valid_limit (index 0), split_erase_write (index 1)
//
// Each request is handled in turn: it is captured, then both slot stores are
// read, updated and written and the result register is loaded; a new request is
// taken only once the last one has been through its update.
// The update cycle waits while an earlier result still sits unaccepted.
// Reset marks every slot as erased at once; no clearing pass is needed.
module slot_stats_smoother_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  sss_in_if.sink                          in_ch,
  sss_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [sss_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [sss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sss_pkg::*;

  sss_cmd_t    cmd;
  sss_result_t result;

  sss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  sss_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .in_slot      (in_ch.slot),
    .in_sample    (in_ch.sample),
    .in_rand_bits (in_ch.rand_bits),
    .result       (result)
  );

  assign out_ch.last_value     = result.last_value;
  assign out_ch.smoothed_value = result.smoothed_value;
  assign out_ch.last_op        = result.last_op;
  assign out_ch.smoothed_op    = result.smoothed_op;

`include "slot_stats_smoother_unit_defines.svh"

  `SSS_ASSERT_NEXT(a_capture_then_busy, cmd.capture, !in_ch.ready)
  `SSS_ASSERT_ALWAYS(a_exec_needs_room, !cmd.exec || !out_ch.valid || out_ch.ready)
  `SSS_ASSERT_NEXT(a_exec_gives_result, cmd.exec, out_ch.valid)
  `SSS_ASSERT_ALWAYS(a_no_capture_and_exec, !(cmd.capture && cmd.exec))

endmodule
